// ===== rtl/cmvg_pkg.sv =====
// Shared types, constants and tables for the capsule mesh vertex generator.
// Used by every module in rtl/. No dependencies.
package cmvg_pkg;

    localparam int COUNT_BITS_DEF   = 8;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 17;
    localparam int CORD_W    = 34;

    localparam logic signed [CORD_W-1:0] ONE30  = 34'sh040000000;
    localparam logic signed [CORD_W-1:0] HALF_T = 34'sh080000000;
    localparam logic signed [CORD_W-1:0] KGAIN  = 34'sd652032874;

    localparam logic [2:0] CFG_DIAMETER   = 3'd0;
    localparam logic [2:0] CFG_CYL_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_SEGMENTS   = 3'd2;
    localparam logic [2:0] CFG_CYL_ROWS   = 3'd3;
    localparam logic [2:0] CFG_HEMI_RINGS = 3'd4;

    localparam logic [1:0] SEC_TOP = 2'd0;
    localparam logic [1:0] SEC_CYL = 2'd1;
    localparam logic [1:0] SEC_BOT = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_SHS, OP_SHC, OP_PB, OP_CB, OP_PA, OP_CA, OP_V, OP_PY,
        OP_NX, OP_NZ, OP_PX, OP_PZ, OP_PYM, OP_OUT
    } t_op;

    typedef struct packed {
        logic load;
        logic div_start;
        logic cor_start;
        logic mul_en;
        logic out_wr;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic v0;
        logic cyl;
        logic div_done;
        logic cor_done;
        logic out_free;
    } t_sts;

    // atan(2^-i) scaled to 2^32 per turn
    function automatic logic signed [CORD_W-1:0] cmvg_atan(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return signed'({4'b0, v});
    endfunction

endpackage

// ===== rtl/capsule_mesh_vertex_generator_top.sv =====
// Capsule mesh vertex generator: one vertex word per request.
// Top level: joins cmvg_ctrl and cmvg_dpath; depends on cmvg_pkg.
//
// Each accepted request word produces one vertex word (position Q9.8, normal
// Q1.14, texture Q1.16, triangle base index). Work runs through one shared
// 40-step bit-serial divider, one shared CORDIC (CORDIC_STEPS iterations)
// and one multiplier, one item at a time. A division or sine/cosine step is
// launched, iterates and then reports done. Every vertex needs three
// divisions, plus two more on the first vertex of a pass for the section
// shares; hemisphere vertices need two sine/cosine steps, cylinder ones one;
// taking the request, control and the multiplies come on top. The input is
// taken only while the sequencer is idle; a finished word waits in the output
// register without blocking the next one, and only a word still stalled when
// the next one is ready holds the sequencer. Configuration writes take effect
// at once and belong between passes.
module capsule_mesh_vertex_generator_top
    import cmvg_pkg::*;
#(
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic signed [17:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [17:0]        o_base_index,
    output logic               o_has_indices,
    output logic               o_last_vertex
);
    t_cmd s_cmd;
    t_sts s_sts;

    cmvg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (s_sts),
        .o_cmd     (s_cmd),
        .o_in_stall(o_in_stall)
    );

    cmvg_dpath #(
        .COUNT_BITS  (COUNT_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_restart    (i_restart),
        .i_out_stall  (i_out_stall),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .o_out_valid  (o_out_valid),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_pos_z      (o_pos_z),
        .o_norm_x     (o_norm_x),
        .o_norm_y     (o_norm_y),
        .o_norm_z     (o_norm_z),
        .o_tex_u      (o_tex_u),
        .o_tex_v      (o_tex_v),
        .o_base_index (o_base_index),
        .o_has_indices(o_has_indices),
        .o_last_vertex(o_last_vertex)
    );

    // the final vertex lies on the bottom pole ring, which carries no triangles
    a_last_no_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_vertex) |-> !o_has_indices)
        else $error("last vertex flagged with indices");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while a vertex is in progress");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_cmd.div_start && s_cmd.cor_start))
        else $error("divider and CORDIC launched together");

    a_out_from_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_wr |-> (s_cmd.op == OP_OUT && s_sts.out_free))
        else $error("output word written outside the output step");
endmodule

// ===== rtl/cmvg_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cmvg_pkg.
module cmvg_div
    import cmvg_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   s_sh, s_diff;
    logic             s_ge;

    always_comb begin
        s_sh   = {r_rem, r_quo[NUM_W-1]};
        s_ge   = s_sh >= {1'b0, r_den};
        s_diff = s_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= s_ge ? s_diff[DEN_W-1:0] : s_sh[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], s_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== rtl/cmvg_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per cycle, quadrant folding up front.
// Depends on cmvg_pkg (atan table, gain, widths).
module cmvg_cordic
    import cmvg_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [31:0]              i_phase,
    output logic                     o_done,
    output logic signed [CORD_W-1:0] o_cos,
    output logic signed [CORD_W-1:0] o_sin
);
    localparam int IW = $clog2(STEPS);

    logic signed [CORD_W-1:0] r_x, r_y, r_a;
    logic                     r_neg, r_busy, r_done;
    logic [IW-1:0]            r_i;
    logic signed [CORD_W-1:0] s_a0, s_a, s_dx, s_dy, s_at;
    logic                     s_neg;

    always_comb begin
        s_a0  = signed'({{(CORD_W-32){i_phase[31]}}, i_phase});
        s_a   = s_a0;
        s_neg = 1'b0;
        if (s_a0 > ONE30) begin
            s_a   = s_a0 - HALF_T;
            s_neg = 1'b1;
        end else if (s_a0 < -ONE30) begin
            s_a   = s_a0 + HALF_T;
            s_neg = 1'b1;
        end
        s_dx = r_y >>> r_i;
        s_dy = r_x >>> r_i;
        s_at = cmvg_atan(5'(r_i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= KGAIN;
                r_y    <= '0;
                r_a    <= s_a;
                r_neg  <= s_neg;
            end else if (r_busy) begin
                if (r_a >= 0) begin
                    r_x <= r_x - s_dx;
                    r_y <= r_y + s_dy;
                    r_a <= r_a - s_at;
                end else begin
                    r_x <= r_x + s_dx;
                    r_y <= r_y - s_dy;
                    r_a <= r_a + s_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;
endmodule

// ===== rtl/cmvg_dpath.sv =====
// Datapath: config registers, mesh counters, shared divider/CORDIC/multiplier,
// output word register. Depends on cmvg_pkg, cmvg_div, cmvg_cordic.
module cmvg_dpath
    import cmvg_pkg::*;
#(
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_restart,
    input  logic               i_out_stall,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic signed [17:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [17:0]        o_base_index,
    output logic               o_has_indices,
    output logic               o_last_vertex
);
    localparam int CntMax = (1 << COUNT_BITS) - 1;

    function automatic logic [7:0] f_eff(input logic [7:0] v);
        if (v == 8'd0) return 8'd1;
        else if (int'(v) > CntMax) return 8'(CntMax);
        else return v;
    endfunction

    function automatic logic signed [17:0] f_sat18(input logic signed [65:0] v);
        if (v > 66'sd131071) return 18'sd131071;
        else if (v < -66'sd131072) return -18'sd131072;
        else return v[17:0];
    endfunction

    function automatic logic signed [15:0] f_nrm(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) return 16'sd16384;
        else if (t < -34'sd16384) return -16'sd16384;
        else return t[15:0];
    endfunction

    // configuration
    logic [15:0] r_diam, r_cylh;
    logic [7:0]  r_segs, r_crows, r_hrings;
    // mesh walk state
    logic [1:0]  r_sec;
    logic [7:0]  r_rr, r_seg;
    logic [17:0] r_vtx;
    logic [16:0] r_sshare, r_cshare;
    // per-vertex work registers
    logic [31:0]        r_phb, r_pha;
    logic [16:0]        r_u;
    logic [24:0]        r_vq;
    logic signed [32:0] r_cb, r_sb, r_ca, r_sa, r_nx, r_nz;
    logic signed [17:0] r_px, r_pz, r_py;
    // output word
    logic               r_out_valid;
    logic signed [17:0] r_o_px, r_o_py, r_o_pz;
    logic signed [15:0] r_o_nx, r_o_ny, r_o_nz;
    logic [16:0]        r_o_u, r_o_v;
    logic [17:0]        r_o_base;
    logic               r_o_hasidx, r_o_last;

    logic [7:0]  s_s, s_c, s_r;
    logic        s_cyl, s_bot, s_final;
    logic [16:0] s_sum;
    logic [DIV_NUM_W-1:0] s_num, s_q;
    logic [DIV_DEN_W-1:0] s_den;
    logic        s_div_done, s_cor_done;
    logic signed [CORD_W-1:0] s_cos, s_sin;
    logic [31:0] s_phase;
    logic [24:0] s_vprod, s_m;
    logic signed [9:0] s_diff;
    logic [8:0]  s_absd;
    logic        s_pyneg;
    logic signed [32:0] s_ma, s_mb, s_rad, s_dext;
    logic signed [65:0] s_prod, s_r30, s_r31, s_hq, s_pyt, s_pyr, s_pyc;
    logic signed [33:0] s_axial;
    logic [26:0] s_vsum;
    logic [16:0] s_v;

    always_comb begin
        s_s     = f_eff(r_segs);
        s_c     = f_eff(r_crows);
        s_r     = f_eff(r_hrings);
        s_cyl   = r_sec == SEC_CYL;
        s_bot   = r_sec >= SEC_BOT;
        s_final = s_bot && (r_rr >= s_r);
        s_sum   = {1'b0, r_diam} + {1'b0, r_cylh};

        s_vprod = {17'b0, r_rr} * {8'b0, (s_cyl ? r_cshare : r_sshare)};
        s_diff  = signed'({2'b0, s_c}) - signed'({1'b0, r_rr, 1'b0});
        s_absd  = s_diff[9] ? 9'(-s_diff) : s_diff[8:0];
        s_m     = {9'b0, r_cylh} * {16'b0, s_absd} + {17'b0, s_c};
        s_pyneg = {1'b0, s_c} < {r_rr, 1'b0};

        s_num = '0;
        s_den = 17'd1;
        case (i_cmd.op)
            OP_SHS: begin
                s_num = {9'b0, r_diam, 15'b0};
                s_den = s_sum;
            end
            OP_SHC: begin
                s_num = {8'b0, r_cylh, 16'b0};
                s_den = s_sum;
            end
            OP_PB: begin
                s_num = {r_seg, 32'b0};
                s_den = {9'b0, s_s};
            end
            OP_PA: begin
                s_num = {2'b0, r_rr, 30'b0};
                s_den = {9'b0, s_r};
            end
            OP_V: begin
                s_num = {15'b0, s_vprod};
                s_den = {9'b0, (s_cyl ? s_c : s_r)};
            end
            OP_PY: begin
                s_num = {15'b0, s_m};
                s_den = {8'b0, s_c, 1'b0};
            end
            default: begin
                s_num = '0;
                s_den = 17'd1;
            end
        endcase

        s_phase = (i_cmd.op == OP_CA) ? r_pha : r_phb;

        s_rad  = s_cyl ? 33'sh040000000 : (s_bot ? r_ca : r_sa);
        s_dext = signed'({17'b0, r_diam});
        case (i_cmd.op)
            OP_NX:   begin s_ma = s_rad;  s_mb = r_cb; end
            OP_NZ:   begin s_ma = s_rad;  s_mb = r_sb; end
            OP_PX:   begin s_ma = s_dext; s_mb = r_nx; end
            OP_PZ:   begin s_ma = s_dext; s_mb = r_nz; end
            OP_PYM:  begin s_ma = s_dext; s_mb = s_bot ? r_sa : r_ca; end
            default: begin s_ma = '0;     s_mb = '0;   end
        endcase
        s_prod = s_ma * s_mb;
        s_r30  = (s_prod + 66'sd536870912) >>> 30;
        s_r31  = (s_prod + 66'sd1073741824) >>> 31;
        s_hq   = signed'({20'b0, r_cylh, 30'b0});
        s_pyt  = s_bot ? (-s_hq - s_prod) : (s_hq + s_prod);
        s_pyr  = (s_pyt + 66'sd1073741824) >>> 31;
        s_pyc  = s_pyneg ? -signed'({41'b0, s_q[24:0]}) : signed'({41'b0, s_q[24:0]});

        s_axial = s_cyl ? 34'sd0 : (s_bot ? -34'(r_sa) : 34'(r_ca));
        s_vsum  = {2'b0, r_vq}
                + ((s_cyl || s_bot) ? {10'b0, r_sshare} : 27'd0)
                + (s_bot ? {10'b0, r_cshare} : 27'd0);
        s_v     = (s_vsum > 27'd65536) ? 17'd65536 : s_vsum[16:0];
    end

    cmvg_div #(
        .NUM_W(DIV_NUM_W),
        .DEN_W(DIV_DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (s_num),
        .i_den  (s_den),
        .o_done (s_div_done),
        .o_quot (s_q)
    );

    cmvg_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.cor_start),
        .i_phase(s_phase),
        .o_done (s_cor_done),
        .o_cos  (s_cos),
        .o_sin  (s_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diam      <= 16'd512;
            r_cylh      <= 16'd512;
            r_segs      <= 8'd16;
            r_crows     <= 8'd4;
            r_hrings    <= 8'd8;
            r_sec       <= SEC_TOP;
            r_rr        <= '0;
            r_seg       <= '0;
            r_vtx       <= '0;
            r_sshare    <= '0;
            r_cshare    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_DIAMETER:   r_diam   <= i_cfg_data;
                    CFG_CYL_HEIGHT: r_cylh   <= i_cfg_data;
                    CFG_SEGMENTS:   r_segs   <= i_cfg_data[7:0];
                    CFG_CYL_ROWS:   r_crows  <= i_cfg_data[7:0];
                    CFG_HEMI_RINGS: r_hrings <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (i_cmd.load && i_restart) begin
                r_sec <= SEC_TOP;
                r_rr  <= '0;
                r_seg <= '0;
                r_vtx <= '0;
            end

            if (s_div_done) begin
                case (i_cmd.op)
                    OP_SHS:  r_sshare <= (s_sum == 17'd0) ? 17'd0 : s_q[16:0];
                    OP_SHC:  r_cshare <= (s_sum == 17'd0) ? 17'd0 : s_q[16:0];
                    OP_PB: begin
                        r_phb <= s_q[31:0];
                        r_u   <= (s_q[39:16] > 24'd65536) ? 17'd65536 : s_q[32:16];
                    end
                    OP_PA:   r_pha <= s_q[31:0];
                    OP_V:    r_vq  <= s_q[24:0];
                    OP_PY:   r_py  <= f_sat18(s_pyc);
                    default: ;
                endcase
            end

            if (s_cor_done) begin
                if (i_cmd.op == OP_CA) begin
                    r_ca <= s_cos[32:0];
                    r_sa <= s_sin[32:0];
                end else begin
                    r_cb <= s_cos[32:0];
                    r_sb <= s_sin[32:0];
                end
            end

            if (i_cmd.mul_en) begin
                case (i_cmd.op)
                    OP_NX:  r_nx <= s_r30[32:0];
                    OP_NZ:  r_nz <= s_r30[32:0];
                    OP_PX:  r_px <= f_sat18(s_r31);
                    OP_PZ:  r_pz <= f_sat18(s_r31);
                    OP_PYM: if (!s_cyl) r_py <= f_sat18(s_pyr);
                    default: ;
                endcase
            end

            if (i_cmd.out_wr) begin
                r_out_valid <= 1'b1;
                r_o_px      <= r_px;
                r_o_py      <= r_py;
                r_o_pz      <= r_pz;
                r_o_nx      <= f_nrm(34'(r_nx));
                r_o_ny      <= f_nrm(s_axial);
                r_o_nz      <= f_nrm(34'(r_nz));
                r_o_u       <= r_u;
                r_o_v       <= s_v;
                r_o_base    <= r_vtx;
                r_o_hasidx  <= !s_final;
                r_o_last    <= s_final && (r_seg >= s_s);

                // advance the walk
                r_vtx <= r_vtx + 1'b1;
                if (r_seg < s_s) begin
                    r_seg <= r_seg + 1'b1;
                end else begin
                    r_seg <= '0;
                    case (r_sec)
                        SEC_TOP: begin
                            if (r_rr >= s_r) begin
                                if (s_c > 8'd1) begin
                                    r_sec <= SEC_CYL;
                                    r_rr  <= 8'd1;
                                end else begin
                                    r_sec <= SEC_BOT;
                                    r_rr  <= '0;
                                end
                            end else begin
                                r_rr <= r_rr + 1'b1;
                            end
                        end
                        SEC_CYL: begin
                            if ({1'b0, r_rr} + 9'd1 >= {1'b0, s_c}) begin
                                r_sec <= SEC_BOT;
                                r_rr  <= '0;
                            end else begin
                                r_rr <= r_rr + 1'b1;
                            end
                        end
                        default: begin
                            if (r_rr >= s_r) begin
                                r_sec <= SEC_TOP;
                                r_rr  <= '0;
                                r_vtx <= '0;
                            end else begin
                                r_rr <= r_rr + 1'b1;
                            end
                        end
                    endcase
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.v0       = (r_sec == SEC_TOP) && (r_rr == 8'd0) && (r_seg == 8'd0);
        o_sts.cyl      = s_cyl;
        o_sts.div_done = s_div_done;
        o_sts.cor_done = s_cor_done;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_o_px;
    assign o_pos_y       = r_o_py;
    assign o_pos_z       = r_o_pz;
    assign o_norm_x      = r_o_nx;
    assign o_norm_y      = r_o_ny;
    assign o_norm_z      = r_o_nz;
    assign o_tex_u       = r_o_u;
    assign o_tex_v       = r_o_v;
    assign o_base_index  = r_o_base;
    assign o_has_indices = r_o_hasidx;
    assign o_last_vertex = r_o_last;
endmodule

// ===== rtl/cmvg_ctrl.sv =====
// Controller: sequences divider, CORDIC and multiplier steps for one vertex.
// Depends on cmvg_pkg (command and status structs).
module cmvg_ctrl
    import cmvg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_SHS, ST_SHC, ST_PB, ST_CB, ST_PA, ST_CA, ST_V, ST_PY,
        ST_NX, ST_NZ, ST_PX, ST_PZ, ST_PYM, ST_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_wait, n_wait;
    logic   s_is_div, s_is_cor, s_done;

    always_comb begin
        o_cmd    = '0;
        o_cmd.op = OP_NONE;
        s_is_div = 1'b0;
        s_is_cor = 1'b0;
        case (r_state)
            ST_IDLE: o_cmd.op = OP_NONE;
            ST_SHS:  begin o_cmd.op = OP_SHS; s_is_div = 1'b1; end
            ST_SHC:  begin o_cmd.op = OP_SHC; s_is_div = 1'b1; end
            ST_PB:   begin o_cmd.op = OP_PB;  s_is_div = 1'b1; end
            ST_CB:   begin o_cmd.op = OP_CB;  s_is_cor = 1'b1; end
            ST_PA:   begin o_cmd.op = OP_PA;  s_is_div = 1'b1; end
            ST_CA:   begin o_cmd.op = OP_CA;  s_is_cor = 1'b1; end
            ST_V:    begin o_cmd.op = OP_V;   s_is_div = 1'b1; end
            ST_PY:   begin o_cmd.op = OP_PY;  s_is_div = 1'b1; end
            ST_NX:   o_cmd.op = OP_NX;
            ST_NZ:   o_cmd.op = OP_NZ;
            ST_PX:   o_cmd.op = OP_PX;
            ST_PZ:   o_cmd.op = OP_PZ;
            ST_PYM:  o_cmd.op = OP_PYM;
            ST_OUT:  o_cmd.op = OP_OUT;
            default: o_cmd.op = OP_NONE;
        endcase
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        // shares are only recomputed on the first vertex
        o_cmd.div_start = s_is_div && !r_wait && ((r_state != ST_SHS) || i_sts.v0);
        o_cmd.cor_start = s_is_cor && !r_wait;
        o_cmd.mul_en    = (r_state == ST_NX) || (r_state == ST_NZ) || (r_state == ST_PX)
                       || (r_state == ST_PZ) || (r_state == ST_PYM);
        o_cmd.out_wr    = (r_state == ST_OUT) && i_sts.out_free;
        o_in_stall      = r_state != ST_IDLE;

        s_done  = r_wait && (s_is_div ? i_sts.div_done : i_sts.cor_done);
        n_state = r_state;
        n_wait  = r_wait;
        if (o_cmd.div_start || o_cmd.cor_start) n_wait = 1'b1;
        if (s_done) n_wait = 1'b0;

        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_SHS;
            ST_SHS: begin
                if (!r_wait && !i_sts.v0) n_state = ST_PB;
                else if (s_done) n_state = ST_SHC;
            end
            ST_SHC: if (s_done) n_state = ST_PB;
            ST_PB:  if (s_done) n_state = ST_CB;
            ST_CB:  if (s_done) n_state = i_sts.cyl ? ST_V : ST_PA;
            ST_PA:  if (s_done) n_state = ST_CA;
            ST_CA:  if (s_done) n_state = ST_V;
            ST_V:   if (s_done) n_state = i_sts.cyl ? ST_PY : ST_NX;
            ST_PY:  if (s_done) n_state = ST_NX;
            ST_NX:  n_state = ST_NZ;
            ST_NZ:  n_state = ST_PX;
            ST_PX:  n_state = ST_PZ;
            ST_PZ:  n_state = ST_PYM;
            ST_PYM: n_state = ST_OUT;
            ST_OUT: if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end
endmodule
